// ===== src/round_robin_class_queue_scheduler_defines.svh =====
// Assertion macros for the round robin class queue scheduler.
`ifndef ROUND_ROBIN_CLASS_QUEUE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_CLASS_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RRCQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RRCQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rrcq_pkg.sv =====
// Shared types and codes for the round robin class queue scheduler.
`timescale 1ns / 1ps

package rrcq_pkg;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DISP = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [2:0] ST_ENQUEUED   = 3'd0;
  localparam logic [2:0] ST_DISPATCHED = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_STOPPED    = 3'd4;
  localparam logic [2:0] ST_STOP_DONE  = 3'd5;

  localparam logic [10:0] PENDING_MAX = 11'd2047;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        job_id;
    logic signed [7:0]  job_class;
  } req_t;

  typedef struct packed {
    logic [2:0]   status;
    logic [63:0]  out_id;
    logic [10:0]  pending_count;
  } rsp_t;

endpackage

// ===== src/rrcq_pick.sv =====
// Rotating first-non-empty class pick over the per-class pending mask.
`timescale 1ns / 1ps

module rrcq_pick #(
  parameter int NUM_CLASSES = 8
) (
  input  logic [NUM_CLASSES-1:0]                                   pend_mask,
  input  logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] start_cls,
  output logic                                                     found,
  output logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] sel
);
  import rrcq_pkg::*;

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [NUM_CLASSES-1:0] upper;
  logic [NUM_CLASSES-1:0] upper_low;
  logic [NUM_CLASSES-1:0] all_low;
  logic [CW-1:0]          upper_sel;
  logic [CW-1:0]          all_sel;

  // classes at or above the pointer come first, then wrap to the bottom
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      upper[i] = pend_mask[i] && (CW'(i) >= start_cls);
    end
  end

  assign upper_low = upper & (~upper + 1'b1);
  assign all_low   = pend_mask & (~pend_mask + 1'b1);

  always_comb begin
    upper_sel = '0;
    all_sel   = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (upper_low[i]) upper_sel = upper_sel | CW'(i);
      if (all_low[i])   all_sel   = all_sel | CW'(i);
    end
  end

  assign found = |pend_mask;
  assign sel   = (|upper) ? upper_sel : all_sel;

endmodule

// ===== src/round_robin_class_queue_scheduler.sv =====
// Top level of the round robin class queue scheduler.
`timescale 1ns / 1ps
`include "round_robin_class_queue_scheduler_defines.svh"

// One FIFO of job ids per priority class, dispatched round robin.
// Command channel: an item (request) is taken when start is high and busy is low.
// Result channel: done pulses for one cycle with result; every item yields one.
// Enqueue: class metadata read, then id write, result the cycle after.
// Dispatch with work pending: metadata read, id store read, then the result
// register, set by the two dependent registered memory reads.
// Stop, empty dispatch, enqueue after stop and the unused command answer at once:
// done is high in the cycle after the accept and busy never rises.
// A new item may be accepted in the cycle that done is high.
// Reset (rst, synchronous) empties all classes, clears the stopped flag and the
// rotating pointer. Per-class metadata entries carry valid bits, so reset and stop
// need no clearing pass. The id store is never cleared.
// The receiver cannot stall: done is a strobe and result holds only until the next result.
module round_robin_class_queue_scheduler #(
  parameter int NUM_CLASSES = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rrcq_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output rrcq_pkg::rsp_t result
);
  import rrcq_pkg::*;

  localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int ACTW = $clog2(NUM_CLASSES + 1);
  localparam int AW   = $clog2(NUM_CLASSES * QUEUE_DEPTH);
  localparam int TOTW = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
  localparam int MW   = 2 * PW + CNTW;
  localparam int DEPTH = NUM_CLASSES * QUEUE_DEPTH;

  localparam logic [AW-1:0]   QD_A     = AW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]   PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(QUEUE_DEPTH);
  localparam logic [CW-1:0]   CLS_TOP  = CW'(NUM_CLASSES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]             state;
  logic [1:0]             cmd_q;
  logic [63:0]            id_q;
  logic [CW-1:0]          cls_q;
  logic [NUM_CLASSES-1:0] pend_mask;
  logic [NUM_CLASSES-1:0] meta_vld;
  logic [CW-1:0]          rot;
  logic [ACTW-1:0]        active;
  logic [TOTW-1:0]        total;
  logic                   stopped;
  logic                   done_next;

  // per-class {head, tail, count}
  logic [MW-1:0]          meta_mem [NUM_CLASSES];
  logic [MW-1:0]          meta_rd;
  logic                   meta_rd_vld;
  logic [63:0]            job_mem [DEPTH];
  logic [63:0]            job_rd;

  logic                   accept;
  logic                   pick_found;
  logic [CW-1:0]          pick_cls;
  logic [CW-1:0]          req_cls;
  logic [CW-1:0]          meta_raddr;
  logic                   is_enq;
  logic [PW-1:0]          m_head;
  logic [PW-1:0]          m_tail;
  logic [CNTW-1:0]        m_cnt;
  logic                   q_full;
  logic [PW-1:0]          head_inc;
  logic [PW-1:0]          tail_inc;
  logic                   meta_we;
  logic [MW-1:0]          meta_wdata;
  logic                   job_we;
  logic [AW-1:0]          job_addr;

  function automatic logic [10:0] sat_pend(input logic [TOTW-1:0] t);
    if (32'(t) > 32'(PENDING_MAX)) return PENDING_MAX;
    return 11'(t);
  endfunction

  function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [63:0] id,
                                  input logic [10:0] pend);
    rsp_t r;
    r.status        = st;
    r.out_id        = id;
    r.pending_count = pend;
    return r;
  endfunction

  rrcq_pick #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_pick (
    .pend_mask(pend_mask),
    .start_cls(rot),
    .found    (pick_found),
    .sel      (pick_cls)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // negative classes go to 0, large ones saturate to the top class
  always_comb begin
    if (request.job_class[7]) begin
      req_cls = '0;
    end else if ({1'b0, request.job_class[6:0]} > 8'(NUM_CLASSES - 1)) begin
      req_cls = CLS_TOP;
    end else begin
      req_cls = CW'(request.job_class[6:0]);
    end
  end

  assign meta_raddr = (request.cmd == CMD_ENQ) ? req_cls : pick_cls;

  assign is_enq = (cmd_q == CMD_ENQ);
  assign {m_head, m_tail, m_cnt} = meta_rd_vld ? meta_rd : '0;
  assign q_full   = (m_cnt == CNT_FULL);
  assign head_inc = (m_head == PTR_LAST) ? '0 : m_head + 1'b1;
  assign tail_inc = (m_tail == PTR_LAST) ? '0 : m_tail + 1'b1;

  assign meta_we    = (state == S_META) && (!is_enq || !q_full);
  assign meta_wdata = is_enq ? {m_head, tail_inc, m_cnt + 1'b1}
                             : {head_inc, m_tail, m_cnt - 1'b1};
  assign job_we     = (state == S_META) && is_enq && !q_full;
  assign job_addr   = AW'(cls_q) * QD_A + AW'(is_enq ? m_tail : m_head);

  // items that answer from idle, the enqueue write-back, and the dispatch read
  always_comb begin
    unique case (state)
      S_IDLE:  done_next = accept && !((request.cmd == CMD_ENQ) && !stopped)
                                  && !((request.cmd == CMD_DISP) && pick_found);
      S_META:  done_next = is_enq;
      S_DATA:  done_next = 1'b1;
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[cls_q] <= meta_wdata;
    meta_rd     <= meta_mem[meta_raddr];
    meta_rd_vld <= meta_vld[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (job_we) job_mem[job_addr] <= id_q;
    job_rd <= job_mem[job_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      pend_mask <= '0;
      meta_vld  <= '0;
      rot       <= '0;
      active    <= '0;
      total     <= '0;
      stopped   <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= request.cmd;
            id_q  <= request.job_id;
            cls_q <= meta_raddr;
            unique case (request.cmd)
              CMD_ENQ: begin
                if (stopped) begin
                  result <= mk_rsp(ST_STOPPED, '0, sat_pend(total));
                end else begin
                  if (ACTW'(req_cls) + ACTW'(1) > active) begin
                    active <= ACTW'(req_cls) + ACTW'(1);
                  end
                  state <= S_META;
                end
              end
              CMD_DISP: begin
                if (pick_found) begin
                  state <= S_META;
                end else begin
                  result <= mk_rsp(ST_EMPTY, '0, sat_pend(total));
                end
              end
              CMD_STOP: begin
                pend_mask <= '0;
                meta_vld  <= '0;
                rot       <= '0;
                active    <= '0;
                total     <= '0;
                stopped   <= 1'b1;
                result    <= mk_rsp(ST_STOP_DONE, '0, '0);
              end
              default: begin
                result <= mk_rsp(ST_EMPTY, '0, sat_pend(total));
              end
            endcase
          end
        end
        S_META: begin
          if (is_enq) begin
            state <= S_IDLE;
            if (q_full) begin
              result <= mk_rsp(ST_FULL, '0, sat_pend(total));
            end else begin
              meta_vld[cls_q]  <= 1'b1;
              pend_mask[cls_q] <= 1'b1;
              total            <= TOTW'(total + 1'b1);
              result <= mk_rsp(ST_ENQUEUED, '0, sat_pend(TOTW'(total + 1'b1)));
            end
          end else begin
            meta_vld[cls_q] <= 1'b1;
            if (m_cnt == CNTW'(1)) pend_mask[cls_q] <= 1'b0;
            total <= TOTW'(total - 1'b1);
            rot   <= (ACTW'(cls_q) + ACTW'(1) == active) ? '0 : CW'(cls_q + 1'b1);
            state <= S_DATA;
          end
        end
        S_DATA: begin
          state  <= S_IDLE;
          result <= mk_rsp(ST_DISPATCHED, job_rd, sat_pend(total));
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RRCQ_ASSERT_NXT(a_accept_progress, accept, done || busy, "accepted item made no progress")
  `RRCQ_ASSERT_IMP(a_no_result_busy, busy, !done, "result strobe while an item is in flight")
  `RRCQ_ASSERT_IMP(a_empty_mask, total == '0, pend_mask == '0, "pending mask set with no jobs")

endmodule

// ===== tb/tb_round_robin_class_queue_scheduler.sv =====
// Self-checking testbench for the round robin class queue scheduler.
`timescale 1ns / 1ps

module tb_round_robin_class_queue_scheduler;
  import rrcq_pkg::*;

  localparam int NUM_CLASSES = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RAND_ITEMS = 1400;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  rsp_t result;

  round_robin_class_queue_scheduler #(
    .NUM_CLASSES(NUM_CLASSES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [63:0] q_ids [NUM_CLASSES][QUEUE_DEPTH];
  int rd_slot [NUM_CLASSES];
  int wr_slot [NUM_CLASSES];
  int fill_lvl [NUM_CLASSES];
  int next_class;
  int live_classes;
  int jobs_waiting;
  bit halted;

  rsp_t awaited_rsp [$];
  int n_errors;
  int n_items, n_results, n_dispatched, n_full, n_dropped_stop;
  int quiet_cycles;

  // typed expectation that rides along with the item on the bus
  bit want_typed;
  rsp_t want_rsp;

  typedef struct {
    req_t item;
    bit typed;
    rsp_t want;
  } row_t;
  row_t rows [$];

  function automatic void clear_queues();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      rd_slot[c] = 0;
      wr_slot[c] = 0;
      fill_lvl[c] = 0;
    end
    next_class = 0;
    live_classes = 0;
    jobs_waiting = 0;
  endfunction

  function automatic rsp_t schedule_step(req_t r);
    rsp_t o;
    int c;
    int q;
    bit found;
    o.status = ST_EMPTY;
    o.out_id = '0;
    found = 1'b0;
    case (r.cmd)
      CMD_ENQ: begin
        if (halted) begin
          o.status = ST_STOPPED;
        end else begin
          if (r.job_class[7]) c = 0;
          else if (int'(r.job_class[6:0]) > NUM_CLASSES - 1) c = NUM_CLASSES - 1;
          else c = int'(r.job_class[6:0]);
          if (c + 1 > live_classes) live_classes = c + 1;
          if (fill_lvl[c] >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            q_ids[c][wr_slot[c]] = r.job_id;
            wr_slot[c] = (wr_slot[c] + 1) % QUEUE_DEPTH;
            fill_lvl[c]++;
            jobs_waiting++;
            o.status = ST_ENQUEUED;
          end
        end
      end
      CMD_DISP: begin
        if (jobs_waiting != 0 && live_classes != 0) begin
          for (int i = 0; i < live_classes; i++) begin
            q = (next_class + i) % live_classes;
            if (!found && fill_lvl[q] != 0) begin
              found = 1'b1;
              o.out_id = q_ids[q][rd_slot[q]];
              rd_slot[q] = (rd_slot[q] + 1) % QUEUE_DEPTH;
              fill_lvl[q]--;
              jobs_waiting--;
              next_class = (q + 1) % live_classes;
              o.status = ST_DISPATCHED;
            end
          end
        end
      end
      CMD_STOP: begin
        clear_queues();
        halted = 1'b1;
        o.status = ST_STOP_DONE;
      end
      default: ;
    endcase
    o.pending_count = (jobs_waiting > int'(PENDING_MAX)) ? PENDING_MAX : jobs_waiting[10:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // results are checked first so an accept on the same edge queues behind them
  always @(posedge clk) begin : monitor
    rsp_t exp_rsp;
    rsp_t pred;
    if (!rst) begin
      if (done) begin
        n_results++;
        if (awaited_rsp.size() == 0) begin
          n_errors++;
          $display("%0t ns: result with nothing expected, actual %0h", $time, result);
        end else begin
          exp_rsp = awaited_rsp.pop_front();
          check_field("status", 64'(exp_rsp.status), 64'(result.status));
          check_field("out_id", exp_rsp.out_id, result.out_id);
          check_field("pending_count", 64'(exp_rsp.pending_count),
                      64'(result.pending_count));
        end
      end
      if (start && !busy) begin
        n_items++;
        pred = schedule_step(request);
        case (pred.status)
          ST_DISPATCHED: n_dispatched++;
          ST_FULL: n_full++;
          ST_STOPPED: n_dropped_stop++;
          default: ;
        endcase
        awaited_rsp.push_back(want_typed ? want_rsp : pred);
      end
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_round_robin_class_queue_scheduler failed");
        $finish;
      end
    end
  end

  task automatic add_row(input logic [1:0] cmd, input logic [63:0] id,
                         input logic [7:0] cls, input bit typed,
                         input logic [2:0] st, input logic [63:0] oid,
                         input logic [10:0] pend);
    row_t r;
    r.item.cmd = cmd;
    r.item.job_id = id;
    r.item.job_class = cls;
    r.typed = typed;
    r.want.status = st;
    r.want.out_id = oid;
    r.want.pending_count = pend;
    rows.push_back(r);
  endtask

  // presents one item from a falling edge and holds it until taken
  task automatic send(input req_t it, input bit typed, input rsp_t want, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 29) begin
      start = 1'b0;
      @(negedge clk);
    end
    request = it;
    want_typed = typed;
    want_rsp = want;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic req_t random_item(int hi_class, bit fill_phase, bit wide_class);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.job_id = {$urandom, $urandom};
    r.job_class = 8'($urandom_range(0, hi_class));
    if ($urandom_range(0, 4) == 0) r.job_class = 8'h80 | 8'($urandom_range(0, 127));
    if (wide_class && $urandom_range(0, 3) == 0) r.job_class = 8'($urandom_range(0, 255));
    if (pick < 2) r.cmd = CMD_NONE;
    else if (pick < (fill_phase ? 72 : 30)) r.cmd = CMD_ENQ;
    else r.cmd = CMD_DISP;
    return r;
  endfunction

  initial begin : stimulus
    int head_rows;
    int seg;
    int hi_class;
    rsp_t none;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    want_typed = 1'b0;
    want_rsp = '0;
    none = '0;
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    n_dispatched = 0;
    n_full = 0;
    n_dropped_stop = 0;
    quiet_cycles = 0;
    halted = 1'b0;
    clear_queues();

    // opening rows: empty block, unused command, id extremes, rotation over two classes
    add_row(CMD_DISP, 64'h0, 8'sd0, 1, ST_EMPTY, 64'h0, 11'd0);
    add_row(CMD_NONE, 64'h0, 8'sd0, 1, ST_EMPTY, 64'h0, 11'd0);
    add_row(CMD_ENQ, 64'h0, 8'sd0, 1, ST_ENQUEUED, 64'h0, 11'd1);
    add_row(CMD_DISP, 64'h0, 8'sd0, 1, ST_DISPATCHED, 64'h0, 11'd0);
    add_row(CMD_ENQ, '1, 8'sd0, 1, ST_ENQUEUED, 64'h0, 11'd1);
    add_row(CMD_DISP, 64'h0, 8'sd0, 1, ST_DISPATCHED, '1, 11'd0);
    add_row(CMD_ENQ, 64'h1111_2222_3333_4444, 8'sd1, 0, none.status, '0, '0);
    add_row(CMD_ENQ, 64'h5555_6666_7777_8888, 8'sd1, 0, none.status, '0, '0);
    add_row(CMD_ENQ, 64'h9999_aaaa_bbbb_cccc, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 1, ST_EMPTY, 64'h0, 11'd0);
    add_row(CMD_ENQ, 64'hdead_beef_0bad_f00d, -8'sd1, 0, none.status, '0, '0);
    add_row(CMD_NONE, '1, 8'h7f, 0, none.status, '0, '0);
    head_rows = rows.size();
    // closing rows: class clamping at both ends, then stop and what follows it
    add_row(CMD_ENQ, 64'h0123_4567_89ab_cdef, 8'h7f, 0, none.status, '0, '0);
    add_row(CMD_ENQ, 64'hfedc_ba98_7654_3210, 8'h80, 0, none.status, '0, '0);
    add_row(CMD_ENQ, 64'h0f0f_0f0f_f0f0_f0f0, 8'sd8, 0, none.status, '0, '0);
    add_row(CMD_ENQ, '1, 8'sd7, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 0, none.status, '0, '0);
    add_row(CMD_STOP, '1, 8'h80, 1, ST_STOP_DONE, 64'h0, 11'd0);
    add_row(CMD_ENQ, '1, 8'sd3, 1, ST_STOPPED, 64'h0, 11'd0);
    add_row(CMD_DISP, 64'h0, 8'sd0, 1, ST_EMPTY, 64'h0, 11'd0);
    add_row(CMD_STOP, 64'h0, 8'sd0, 1, ST_STOP_DONE, 64'h0, 11'd0);
    add_row(CMD_NONE, 64'h0, 8'sd0, 1, ST_EMPTY, 64'h0, 11'd0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < head_rows; i++)
      send(rows[i].item, rows[i].typed, rows[i].want, 1'b1);

    // stop latches for good, so the random part never stops; the active class
    // count only grows, so the class range widens segment by segment
    for (int i = 0; i < RAND_ITEMS; i++) begin
      seg = i / (RAND_ITEMS / 5);
      hi_class = (seg == 0) ? 1 : (seg == 1) ? 2 : (seg == 2) ? 4 : NUM_CLASSES - 1;
      send(random_item(hi_class, (i % 100) < 60, seg >= 4), 1'b0, none,
           !(i >= 700 && i < 900));
    end

    for (int i = head_rows; i < rows.size(); i++)
      send(rows[i].item, rows[i].typed, rows[i].want, 1'b1);
    start = 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d items and %0d results: %0d jobs dispatched, %0d full-class drops,",
             n_items, n_results, n_dispatched, n_full);
    $display("%0d enqueues dropped after stop, class ranges widened from two classes to all.",
             n_dropped_stop);
    if (n_errors == 0 && awaited_rsp.size() == 0) begin
      $display("tb_round_robin_class_queue_scheduler passed");
    end else begin
      $display("tb_round_robin_class_queue_scheduler failed");
    end
    $finish;
  end

endmodule
